FILE: sv/aes128_round_key_step_defines.svh
// ----------------------------------------------------------------------------
// aes128_round_key_step_defines.svh
// assertion macros shared by the round key step checker
// ----------------------------------------------------------------------------
`ifndef AES128_ROUND_KEY_STEP_DEFINES_SVH
`define AES128_ROUND_KEY_STEP_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define ARK_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property that must also hold while reset is applied
`define ARK_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

FILE: sv/ark_pkg.sv
// ----------------------------------------------------------------------------
// ark_pkg
// widths, opcodes, sequencer states and the key schedule tables
// ----------------------------------------------------------------------------
package ark_pkg;

    localparam int KEY_W  = 128;
    localparam int HALF_W = 64;
    localparam int RND_W  = 4;

    localparam logic [RND_W-1:0] MAX_ROUND = RND_W'(10);

    localparam logic OP_FWD = 1'b0;
    localparam logic OP_BWD = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } ark_state_t;

    // control from the sequencer to the key datapath
    typedef struct packed {
        logic             load;
        logic             step;
        logic             dir;
        logic [RND_W-1:0] rnd;
    } ark_ctl_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] ark_sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    // round constant of round rnd (1..10)
    function automatic logic [7:0] ark_rcon(input logic [RND_W-1:0] rnd);
        logic [7:0] rc;
        case (rnd)
            4'd1:    rc = 8'h01;
            4'd2:    rc = 8'h02;
            4'd3:    rc = 8'h04;
            4'd4:    rc = 8'h08;
            4'd5:    rc = 8'h10;
            4'd6:    rc = 8'h20;
            4'd7:    rc = 8'h40;
            4'd8:    rc = 8'h80;
            4'd9:    rc = 8'h1b;
            4'd10:   rc = 8'h36;
            default: rc = 8'h00;
        endcase
        return rc;
    endfunction

endpackage

FILE: sv/ark_req_if.sv
// ----------------------------------------------------------------------------
// ark_req_if
// request channel: opcode, round number and key
// ----------------------------------------------------------------------------
interface ark_req_if;
    import ark_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [RND_W-1:0]  round_number;
    logic [HALF_W-1:0] key_high;
    logic [HALF_W-1:0] key_low;

    modport source (
        output valid,
        output opcode,
        output round_number,
        output key_high,
        output key_low,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  round_number,
        input  key_high,
        input  key_low,
        output ready
    );
endinterface

FILE: sv/ark_rsp_if.sv
// ----------------------------------------------------------------------------
// ark_rsp_if
// response channel: result key and bad round flag
// ----------------------------------------------------------------------------
interface ark_rsp_if;
    import ark_pkg::*;

    logic              valid;
    logic              ready;
    logic [HALF_W-1:0] result_high;
    logic [HALF_W-1:0] result_low;
    logic              bad_round;

    modport source (
        output valid,
        output result_high,
        output result_low,
        output bad_round,
        input  ready
    );

    modport sink (
        input  valid,
        input  result_high,
        input  result_low,
        input  bad_round,
        output ready
    );
endinterface

FILE: sv/ark_round_unit.sv
// ----------------------------------------------------------------------------
// ark_round_unit
// one key schedule round, forward or backward, shared over all iterations
// ----------------------------------------------------------------------------
module ark_round_unit (
    input  logic [ark_pkg::KEY_W-1:0] key,
    input  logic                      dir,
    input  logic [ark_pkg::RND_W-1:0] rnd,
    output logic [ark_pkg::KEY_W-1:0] key_next
);
    import ark_pkg::*;

    logic [7:0] k   [16];
    logic [7:0] n   [16];
    logic [7:0] sel [4];
    logic [7:0] sub [4];

    for (genvar i = 0; i < 16; i++) begin : g_unpack
        assign k[i] = key[KEY_W-1-8*i -: 8];
        assign key_next[KEY_W-1-8*i -: 8] = n[i];
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        // backward: last column of the previous key is k2 ^ k3 of the row below
        assign sel[r] = k[((r+1)%4)*4+3] ^ ((dir == OP_BWD) ? k[((r+1)%4)*4+2] : 8'h00);
        if (r == 0) begin : g_rc
            assign sub[r] = ark_sbox(sel[r]) ^ ark_rcon(rnd);
        end
        else begin : g_norc
            assign sub[r] = ark_sbox(sel[r]);
        end
        assign n[r*4] = k[r*4] ^ sub[r];
        for (genvar c = 1; c < 4; c++) begin : g_col
            assign n[r*4+c] = (dir == OP_BWD) ? (k[r*4+c-1] ^ k[r*4+c])
                                              : (n[r*4+c-1] ^ k[r*4+c]);
        end
    end
endmodule

FILE: sv/ark_seq.sv
// ----------------------------------------------------------------------------
// ark_seq
// sequencer: range check, round countdown and handshake control
// ----------------------------------------------------------------------------
module ark_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_opcode,
    input  logic [ark_pkg::RND_W-1:0] in_round,
    input  logic                      out_ready,
    output logic                      in_ready,
    output logic                      out_valid,
    output logic                      bad_round,
    output ark_pkg::ark_ctl_t         ctl
);
    import ark_pkg::*;

    ark_state_t       state_reg, state_next;
    logic [RND_W-1:0] rnd_reg, rnd_next;
    logic             op_reg, op_next;
    logic             bad_reg, bad_next;
    logic             accept;
    logic             bad_in;
    logic             skip_in;
    logic             last;

    assign bad_in  = (in_opcode == OP_FWD) ? ((in_round == '0) || (in_round > MAX_ROUND))
                                           : (in_round > MAX_ROUND);
    assign skip_in = bad_in || (in_round == '0);
    assign last    = (op_reg == OP_FWD) || (rnd_reg == RND_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg   <= '0;
            op_reg    <= OP_FWD;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            op_reg    <= op_next;
            bad_reg   <= bad_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = skip_in ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                if (last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        out_valid = (state_reg == ST_DONE);
        accept    = in_ready && in_valid;
        ctl.load  = accept;
        ctl.step  = (state_reg == ST_RUN);
        ctl.dir   = op_reg;
        ctl.rnd   = rnd_reg;
        bad_round = bad_reg;
    end

    // item registers
    always_comb
    begin
        rnd_next = rnd_reg;
        op_next  = op_reg;
        bad_next = bad_reg;
        if (accept)
        begin
            rnd_next = in_round;
            op_next  = in_opcode;
            bad_next = bad_in;
        end
        else if ((state_reg == ST_RUN) && (op_reg == OP_BWD))
            rnd_next = rnd_reg - RND_W'(1);
    end
endmodule

FILE: sv/aes128_round_key_step.sv
// ----------------------------------------------------------------------------
// aes128_round_key_step
// aes-128 key schedule step: next round key, or master key from a round key
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------
//  req     | in  | opcode, round_number, key_high, key_low
//  rsp     | out | result_high, result_low, bad_round
//
//  one item at a time; forward: one round unit pass in ST_RUN, then the result in ST_DONE
//  backward: round_number passes (up to 10) in ST_RUN, then the result in ST_DONE
//  out-of-range round or backward round zero: result in the cycle after accept
//  req.ready is low from accept until the response beat is taken
//  rst_n clears the sequencer; the key register carries no reset
// ----------------------------------------------------------------------------
module aes128_round_key_step (
    input  logic         clk,
    input  logic         rst_n,
    ark_req_if.sink      req,
    ark_rsp_if.source    rsp
);
    import ark_pkg::*;

    ark_ctl_t         ctl;
    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic [KEY_W-1:0] round_out;

    // range check and round countdown
    ark_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_round  (req.round_number),
        .out_ready (rsp.ready),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .bad_round (rsp.bad_round),
        .ctl       (ctl)
    );

    // shared round datapath, fed back from the key register
    ark_round_unit u_round (
        .key      (key_reg),
        .dir      (ctl.dir),
        .rnd      (ctl.rnd),
        .key_next (round_out)
    );

    // load on accept, update once per round step, hold otherwise
    always_comb
    begin
        key_next = key_reg;
        if (ctl.load)
            key_next = {req.key_high, req.key_low};
        else if (ctl.step)
            key_next = round_out;
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    // the key register doubles as the output register
    assign rsp.result_high = key_reg[KEY_W-1 -: HALF_W];
    assign rsp.result_low  = key_reg[HALF_W-1:0];
endmodule

FILE: sv/ark_chk.sv
// ----------------------------------------------------------------------------
// ark_chk
// port-level checks for the round key step, bound to the top level
// ----------------------------------------------------------------------------
`include "aes128_round_key_step_defines.svh"

module ark_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       opcode,
    input logic [ark_pkg::RND_W-1:0]  round_number,
    input logic [ark_pkg::HALF_W-1:0] key_high,
    input logic [ark_pkg::HALF_W-1:0] key_low,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ark_pkg::HALF_W-1:0] result_high,
    input logic [ark_pkg::HALF_W-1:0] result_low,
    input logic                       bad_round
);
    import ark_pkg::*;

    logic             acc;
    logic [KEY_W-1:0] key_in;
    logic [KEY_W-1:0] key_out;
    logic [KEY_W-1:0] key_in_reg;
    logic [KEY_W:0]   rsp_all;
    logic             stall;
    logic             bad_acc;
    logic             zero_acc;
    logic             rsp_kept;

    assign acc      = in_valid && in_ready;
    assign key_in   = {key_high, key_low};
    assign key_out  = {result_high, result_low};
    assign rsp_all  = {key_out, bad_round};
    assign stall    = out_valid && !out_ready;
    assign bad_acc  = acc && (round_number > MAX_ROUND);
    assign zero_acc = acc && (opcode == OP_BWD) && (round_number == '0);

    // key offered at the previous edge
    always_ff @(posedge clk)
    begin
        key_in_reg <= key_in;
    end

    assign rsp_kept = out_valid && (key_out == key_in_reg);

    // one item at a time: no new beat while a response waits
    `ARK_ASSERT(a_one_item, !(out_valid && in_ready), "input ready while result pending")

    // stalled response beat holds
    `ARK_ASSERT(a_rsp_hold, stall |=> out_valid && $stable(rsp_all), "stalled response changed")

    // round above ten passes the key through and flags it
    `ARK_ASSERT(a_bad_pass, bad_acc |=> rsp_kept && bad_round, "bad round not passed through")

    // backward round zero returns the key unflagged
    `ARK_ASSERT(a_bwd_zero, zero_acc |=> rsp_kept && !bad_round, "round zero altered key")
endmodule

bind aes128_round_key_step ark_chk u_ark_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (req.valid),
    .in_ready     (req.ready),
    .opcode       (req.opcode),
    .round_number (req.round_number),
    .key_high     (req.key_high),
    .key_low      (req.key_low),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .result_high  (rsp.result_high),
    .result_low   (rsp.result_low),
    .bad_round    (rsp.bad_round)
);

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the aes-128 round key step
// ----------------------------------------------------------------------------
// request beats go in with random bursts and gaps, and the response side
// stalls on its own changing pattern. Every accepted request without a given
// answer is run through a local key schedule model. That model builds its own
// s-box from the field inverse and the affine map. The expected key is queued,
// and each response beat is checked field by field against the oldest entry.
// A short table of directed beats comes first. It covers the round limits,
// out-of-range rounds, backward round zero, and all-zero and all-one keys.
// Random beats follow; nearly half walk a master key to round ten and back.
// ----------------------------------------------------------------------------
module tb_top;
    import ark_pkg::*;

    localparam int RANDOM_BEATS = 750;
    localparam int SHOWN_ERRORS = 10;

    typedef logic [KEY_W-1:0] key128_t;

    // one response beat as the bench expects it
    typedef struct packed {
        logic [HALF_W-1:0] key_high;
        logic [HALF_W-1:0] key_low;
        logic              bad_round;
    } round_key_t;

    // one row of the directed table; given rows carry a hand-written answer
    typedef struct packed {
        logic              opcode;
        logic [RND_W-1:0]  round_number;
        logic [HALF_W-1:0] key_high;
        logic [HALF_W-1:0] key_low;
        logic              given;
        round_key_t        want;
    } key_vector_t;

    localparam int DIRECTED_ROWS = 17;

    // the fips-197 sample master key, used as an ordinary pattern
    localparam logic [HALF_W-1:0] FIPS_HI = 64'h2b7e151628aed2a6;
    localparam logic [HALF_W-1:0] FIPS_LO = 64'habf7158809cf4f3c;
    localparam logic [HALF_W-1:0] ALL_ONE = 64'hffffffffffffffff;

    localparam key_vector_t DIRECTED [DIRECTED_ROWS] = '{
        // zero key, round 1: row 0 gets sbox(0)^rcon, the other rows sbox(0)
        '{OP_FWD, 4'd1, 64'h0, 64'h0, 1'b1,
          '{64'h6262626263636363, 64'h6363636363636363, 1'b0}},
        // all-ones key, round 1: sbox(ff) = 16 chained through the ones
        '{OP_FWD, 4'd1, ALL_ONE, ALL_ONE, 1'b1,
          '{64'he817e817e916e916, 64'he916e916e916e916, 1'b0}},
        // forward round zero and above ten: key passes, flag raised
        '{OP_FWD, 4'd0, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1,
          '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1}},
        '{OP_FWD, 4'd11, 64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0, 1'b1,
          '{64'h0f1e2d3c4b5a6978, 64'h8796a5b4c3d2e1f0, 1'b1}},
        '{OP_FWD, 4'd15, ALL_ONE, ALL_ONE, 1'b1,
          '{ALL_ONE, ALL_ONE, 1'b1}},
        // backward round zero: key passes, no flag
        '{OP_BWD, 4'd0, FIPS_HI, FIPS_LO, 1'b1,
          '{FIPS_HI, FIPS_LO, 1'b0}},
        // backward above ten: key passes, flag raised
        '{OP_BWD, 4'd11, 64'h0, ALL_ONE, 1'b1,
          '{64'h0, ALL_ONE, 1'b1}},
        '{OP_BWD, 4'd15, 64'h0, 64'h0, 1'b1,
          '{64'h0, 64'h0, 1'b1}},
        // the rest go through the model
        '{OP_FWD, 4'd10, ALL_ONE, ALL_ONE, 1'b0, '0},
        '{OP_FWD, 4'd9, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, '0},
        '{OP_FWD, 4'd5, FIPS_HI, FIPS_LO, 1'b0, '0},
        '{OP_FWD, 4'd2, 64'h8000000000000001, 64'h0000000180000000, 1'b0, '0},
        '{OP_BWD, 4'd1, 64'h0, 64'h0, 1'b0, '0},
        '{OP_BWD, 4'd10, 64'h0, 64'h0, 1'b0, '0},
        '{OP_BWD, 4'd10, ALL_ONE, ALL_ONE, 1'b0, '0},
        '{OP_BWD, 4'd5, FIPS_HI, FIPS_LO, 1'b0, '0},
        '{OP_BWD, 4'd1, ALL_ONE, 64'h0, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    ark_req_if req ();
    ark_rsp_if rsp ();

    aes128_round_key_step u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // keys still owed by the block, oldest first
    round_key_t expected_keys [$];

    int mismatches    = 0;
    int results_seen  = 0;
    int forward_beats = 0;
    int backward_beats = 0;
    int bad_beats     = 0;
    int chains_closed = 0;
    int burst_left    = 0;

    // ------------------------------------------------------------------------
    // key schedule model
    // ------------------------------------------------------------------------

    // multiply by x in gf(2^8) mod x^8+x^4+x^3+x+1
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] x;
        acc = 8'h00;
        x   = a;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                acc = acc ^ x;
            x = xtime(x);
        end
        return acc;
    endfunction

    // s-box from first principles: a^254 is the inverse (0 maps to 0),
    // then the affine map with constant 63
    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        logic [7:0] sq;
        logic [7:0] inv;
        sq  = a;
        inv = 8'h01;
        for (int i = 1; i < 8; i++)
        begin
            sq  = gf_mul(sq, sq);
            inv = gf_mul(inv, sq);
        end
        return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                   ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
    endfunction

    // round constant: x^(rnd-1)
    function automatic logic [7:0] round_const(input logic [RND_W-1:0] rnd);
        logic [7:0] rc;
        rc = 8'h01;
        for (int i = 1; i < int'(rnd); i++)
            rc = xtime(rc);
        return rc;
    endfunction

    // byte idx of the key, byte 0 in the top bits
    function automatic logic [7:0] key_byte(input key128_t k, input int idx);
        return k[KEY_W - 1 - 8 * idx -: 8];
    endfunction

    // one expansion step: key of round rnd-1 to key of round rnd
    function automatic key128_t forward_round(input key128_t k, input logic [RND_W-1:0] rnd);
        key128_t    n;
        logic [7:0] t;
        n = '0;
        for (int r = 0; r < 4; r++)
        begin
            // last column, rotated up one row
            t = sub_byte(key_byte(k, ((r + 1) % 4) * 4 + 3));
            if (r == 0)
                t = t ^ round_const(rnd);
            n[KEY_W - 1 - 8 * (r * 4) -: 8] = key_byte(k, r * 4) ^ t;
            for (int c = 1; c < 4; c++)
                n[KEY_W - 1 - 8 * (r * 4 + c) -: 8] =
                    key_byte(n, r * 4 + c - 1) ^ key_byte(k, r * 4 + c);
        end
        return n;
    endfunction

    // undo one step: key of round rnd to key of round rnd-1
    function automatic key128_t backward_round(input key128_t k, input logic [RND_W-1:0] rnd);
        key128_t    p;
        logic [7:0] t;
        p = '0;
        // columns 1..3 unchain directly
        for (int r = 0; r < 4; r++)
            for (int c = 1; c < 4; c++)
                p[KEY_W - 1 - 8 * (r * 4 + c) -: 8] =
                    key_byte(k, r * 4 + c - 1) ^ key_byte(k, r * 4 + c);
        // column 0 needs the recovered last column
        for (int r = 0; r < 4; r++)
        begin
            t = sub_byte(key_byte(p, ((r + 1) % 4) * 4 + 3));
            if (r == 0)
                t = t ^ round_const(rnd);
            p[KEY_W - 1 - 8 * (r * 4) -: 8] = key_byte(k, r * 4) ^ t;
        end
        return p;
    endfunction

    function automatic round_key_t schedule_key(input logic op, input logic [RND_W-1:0] rnd,
                                                input logic [HALF_W-1:0] kh,
                                                input logic [HALF_W-1:0] kl);
        key128_t    k;
        round_key_t res;
        k = {kh, kl};
        if (op == OP_FWD)
        begin
            res.bad_round = (rnd == '0) || (rnd > MAX_ROUND);
            if (!res.bad_round)
                k = forward_round(k, rnd);
        end
        else
        begin
            res.bad_round = (rnd > MAX_ROUND);
            if (!res.bad_round)
                for (int i = int'(rnd); i > 0; i--)
                    k = backward_round(k, RND_W'(i));
        end
        res.key_high = k[KEY_W-1:HALF_W];
        res.key_low  = k[HALF_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------

    // mostly random halves, now and then all zeros or all ones
    function automatic logic [HALF_W-1:0] rand_half();
        logic [HALF_W-1:0] v;
        case ($urandom_range(0, 15))
            0:       v = '0;
            1:       v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    // with valid still high, or after a random idle gap with valid low once the burst ran out
    task automatic send_key(input logic op, input logic [RND_W-1:0] rnd,
                            input logic [HALF_W-1:0] kh, input logic [HALF_W-1:0] kl,
                            input round_key_t want);
        req.valid        <= 1'b1;
        req.opcode       <= op;
        req.round_number <= rnd;
        req.key_high     <= kh;
        req.key_low      <= kl;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        // accepted at this edge
        expected_keys.push_back(want);
        if (want.bad_round)
            bad_beats++;
        else if (op == OP_FWD)
            forward_beats++;
        else
            backward_beats++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 20))
                @(negedge clk);
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    initial
    begin : stimulus
        key_vector_t       row;
        round_key_t        want;
        logic              op;
        logic [RND_W-1:0]  rnd;
        logic [HALF_W-1:0] kh;
        logic [HALF_W-1:0] kl;
        key128_t           chain_key;
        logic [RND_W-1:0]  chain_round;
        logic              chain_fwd;
        int                pick;

        rst_n            = 1'b0;
        req.valid        = 1'b0;
        req.opcode       = OP_FWD;
        req.round_number = '0;
        req.key_high     = '0;
        req.key_low      = '0;
        chain_key        = {rand_half(), rand_half()};
        chain_round      = '0;

        repeat (11)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row  = DIRECTED[i];
            want = row.given ? row.want
                             : schedule_key(row.opcode, row.round_number,
                                            row.key_high, row.key_low);
            send_key(row.opcode, row.round_number, row.key_high, row.key_low, want);
        end

        // random part; the chain walks a master key up to round ten, then
        // asks for the master key back from the round ten key
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            chain_fwd = 1'b0;
            pick      = $urandom_range(0, 99);
            if (pick < 45)
            begin
                kh = chain_key[KEY_W-1:HALF_W];
                kl = chain_key[HALF_W-1:0];
                if (chain_round == MAX_ROUND)
                begin
                    op          = OP_BWD;
                    rnd         = MAX_ROUND;
                    chain_round = '0;
                    chain_key   = {rand_half(), rand_half()};
                    chains_closed++;
                end
                else
                begin
                    op          = OP_FWD;
                    rnd         = chain_round + RND_W'(1);
                    chain_round = rnd;
                    chain_fwd   = 1'b1;
                end
            end
            else if (pick < 70)
            begin
                op  = OP_BWD;
                rnd = RND_W'($urandom_range(0, 10));
                kh  = rand_half();
                kl  = rand_half();
            end
            else if (pick < 85)
            begin
                op  = OP_FWD;
                rnd = RND_W'($urandom_range(1, 10));
                kh  = rand_half();
                kl  = rand_half();
            end
            else
            begin
                // noise: any opcode, any round, out-of-range ones included
                op  = ($urandom_range(0, 1) == 1) ? OP_BWD : OP_FWD;
                rnd = RND_W'($urandom_range(0, 15));
                kh  = rand_half();
                kl  = rand_half();
            end
            want = schedule_key(op, rnd, kh, kl);
            if (chain_fwd)
                chain_key = {want.key_high, want.key_low};
            send_key(op, rnd, kh, kl, want);
        end
        req.valid <= 1'b0;

        // drain, then give the block time to show any stray beat
        while (expected_keys.size() != 0)
            @(posedge clk);
        repeat (24)
            @(posedge clk);

        $display("%0d request beats: %0d forward, %0d backward, %0d with bad round",
                 forward_beats + backward_beats + bad_beats, forward_beats,
                 backward_beats, bad_beats);
        $display("%0d result beats checked, %0d key chains taken to round ten and back",
                 results_seen, chains_closed);
        if (mismatches == 0 && expected_keys.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // response side
    // ------------------------------------------------------------------------

    // receiver stalls: always ready, coin flip, mostly stalled, or alternating
    initial
    begin : rsp_stall
        int mode;
        int span;
        rsp.ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 80);
            for (int i = 0; i < span; i++)
            begin
                @(negedge clk);
                case (mode)
                    0:       rsp.ready <= 1'b1;
                    1:       rsp.ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp.ready <= ($urandom_range(0, 4) == 0);
                    default: rsp.ready <= (i % 2 == 0);
                endcase
            end
        end
    end

    function automatic void note_mismatch(input string field, input logic [HALF_W-1:0] want,
                                          input logic [HALF_W-1:0] got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    // compare each result beat with the oldest pending key
    always @(posedge clk)
    begin : result_check
        round_key_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            results_seen++;
            if (expected_keys.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS)
                    $display("%0t: result beat with no request pending: %h %h %b", $time,
                             rsp.result_high, rsp.result_low, rsp.bad_round);
            end
            else
            begin
                want = expected_keys.pop_front();
                if (rsp.result_high !== want.key_high)
                    note_mismatch("result_high", want.key_high, rsp.result_high);
                if (rsp.result_low !== want.key_low)
                    note_mismatch("result_low", want.key_low, rsp.result_low);
                if (rsp.bad_round !== want.bad_round)
                    note_mismatch("bad_round", HALF_W'(want.bad_round),
                                  HALF_W'(rsp.bad_round));
            end
        end
    end

    // hard stop well past the slowest legal run
    initial
    begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/ark_pkg.sv
sv/ark_req_if.sv
sv/ark_rsp_if.sv
sv/ark_round_unit.sv
sv/ark_seq.sv
sv/aes128_round_key_step.sv
sv/ark_chk.sv
tb/tb_top.sv
